>>> design/mdr_pkg.sv
// Shared types, register indexes and sequencer constants of the mho distance relay.
package mdr_pkg;

  // Widths fixed by the phasor and register formats.
  localparam int PHASOR_W    = 16;
  localparam int RADIUS_W    = 15;
  localparam int DELAY_W     = 16;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_BREAKER_DELAY_TICKS = 5;
  localparam int          DEF_COUNT_WIDTH         = 16;
  localparam int          DEF_QUEUE_DEPTH         = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_Z1_CENTER_RE = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_Z1_CENTER_IM = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_Z1_RADIUS    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Z2_CENTER_RE = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_Z2_CENTER_IM = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_Z2_RADIUS    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_Z1_DELAY     = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_Z2_DELAY     = 4'd7;

  // Item kinds decided by the front end.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Multiplier schedule: two steps for |I|^2, eight per zone, one final compare.
  localparam int STEP_W     = 5;
  localparam int ZONE2_BASE = 2;
  localparam int ZONE1_BASE = 10;
  localparam int STEP_LAST  = 18;

  // Zone select codes.
  localparam logic ZONE_2 = 1'b0;
  localparam logic ZONE_1 = 1'b1;

  // Multiplier operation codes, carried along with the product.
  localparam int MOP_W = 4;
  localparam logic [MOP_W-1:0] MOP_NONE = 4'd0;
  localparam logic [MOP_W-1:0] MOP_IR2  = 4'd1;
  localparam logic [MOP_W-1:0] MOP_II2  = 4'd2;
  localparam logic [MOP_W-1:0] MOP_RR   = 4'd3;
  localparam logic [MOP_W-1:0] MOP_CRIR = 4'd4;
  localparam logic [MOP_W-1:0] MOP_CIII = 4'd5;
  localparam logic [MOP_W-1:0] MOP_CRII = 4'd6;
  localparam logic [MOP_W-1:0] MOP_CIIR = 4'd7;
  localparam logic [MOP_W-1:0] MOP_RHS  = 4'd8;
  localparam logic [MOP_W-1:0] MOP_DR2  = 4'd9;
  localparam logic [MOP_W-1:0] MOP_DI2  = 4'd10;

  // Relay settings as held by the register file.
  typedef struct packed {
    logic signed [PHASOR_W-1:0] z1_center_re;
    logic signed [PHASOR_W-1:0] z1_center_im;
    logic        [RADIUS_W-1:0] z1_radius;
    logic signed [PHASOR_W-1:0] z2_center_re;
    logic signed [PHASOR_W-1:0] z2_center_im;
    logic        [RADIUS_W-1:0] z2_radius;
    logic        [DELAY_W-1:0]  z1_delay;
    logic        [DELAY_W-1:0]  z2_delay;
  } cfg_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    logic                       kind;
    logic signed [PHASOR_W-1:0] volt_re;
    logic signed [PHASOR_W-1:0] volt_im;
    logic signed [PHASOR_W-1:0] curr_re;
    logic signed [PHASOR_W-1:0] curr_im;
  } q_entry_t;

endpackage

>>> design/mdr_if.sv
// Handshake channel interfaces of the mho distance relay.
interface mdr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mdr_pkg::PHASOR_W-1:0] volt_re;
  logic signed [mdr_pkg::PHASOR_W-1:0] volt_im;
  logic signed [mdr_pkg::PHASOR_W-1:0] curr_re;
  logic signed [mdr_pkg::PHASOR_W-1:0] curr_im;
  logic                                clear;

  modport source (output valid, volt_re, volt_im, curr_re, curr_im, clear, input ready);
  modport sink   (input valid, volt_re, volt_im, curr_re, curr_im, clear, output ready);
endinterface

interface mdr_out_if;
  logic valid;
  logic ready;
  logic trip;
  logic trip_prev;
  logic pickup;

  modport source (output valid, trip, trip_prev, pickup, input ready);
  modport sink   (input valid, trip, trip_prev, pickup, output ready);
endinterface

interface mdr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mdr_pkg::CFG_INDEX_W-1:0]     index;
  logic [mdr_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/mdr_front.sv
// Front end: takes input items, classifies them and pushes them into the queue.
module mdr_front (
  input  logic              clk,
  input  logic              rst_n,
  mdr_in_if.sink            in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output mdr_pkg::q_entry_t push_item
);

  logic              hold_valid_r;
  logic              hold_valid_nxt;
  mdr_pkg::q_entry_t hold_r;
  mdr_pkg::q_entry_t hold_nxt;
  logic              in_fire;

  // The holding register frees up whenever the queue takes its item.
  assign in_ch.ready = !hold_valid_r || push_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push_valid  = hold_valid_r;
  assign push_item   = hold_r;

  // Classify the item; a clear item carries no phasors.
  always_comb begin
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    if (in_fire) begin
      hold_valid_nxt = 1'b1;
      if (in_ch.clear) begin
        hold_nxt.kind    = mdr_pkg::KIND_CLEAR;
        hold_nxt.volt_re = '0;
        hold_nxt.volt_im = '0;
        hold_nxt.curr_re = '0;
        hold_nxt.curr_im = '0;
      end else begin
        hold_nxt.kind    = mdr_pkg::KIND_TICK;
        hold_nxt.volt_re = in_ch.volt_re;
        hold_nxt.volt_im = in_ch.volt_im;
        hold_nxt.curr_re = in_ch.curr_re;
        hold_nxt.curr_im = in_ch.curr_im;
      end
    end else if (push_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

>>> design/mdr_queue.sv
// Small first-in first-out queue between the front and back ends.
module mdr_queue #(
  parameter int DEPTH = mdr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  mdr_pkg::q_entry_t push_item,
  output logic              pop_valid,
  input  logic              pop,
  output mdr_pkg::q_entry_t pop_item
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mdr_pkg::q_entry_t slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> design/mdr_back.sv
// Back end: zone circle tests on a shared multiplier, relay counters and result register.
module mdr_back #(
  parameter int unsigned BREAKER_DELAY_TICKS = mdr_pkg::DEF_BREAKER_DELAY_TICKS,
  parameter int          COUNT_WIDTH         = mdr_pkg::DEF_COUNT_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mdr_pkg::cfg_t     cfg,
  input  logic              pop_valid,
  output logic              pop,
  input  mdr_pkg::q_entry_t pop_item,
  mdr_out_if.source         out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int CWID = COUNT_WIDTH;

  logic [1:0]                    state_r;
  logic [1:0]                    state_nxt;
  logic [mdr_pkg::STEP_W-1:0]    step_r;
  mdr_pkg::q_entry_t             item_r;

  // Datapath registers.
  logic signed [32:0]            mul_a;
  logic signed [32:0]            mul_b;
  logic [mdr_pkg::MOP_W-1:0]     mop;
  logic                          mzone;
  logic signed [65:0]            p_r;
  logic [mdr_pkg::MOP_W-1:0]     mop_r;
  logic                          mzone_r;
  logic [31:0]                   i2_r;
  logic [29:0]                   rr_r;
  logic signed [32:0]            dr_r;
  logic signed [32:0]            di_r;
  logic [63:0]                   rhs_r;
  logic [63:0]                   lhs_r;
  logic                          in_z1_r;
  logic                          in_z2_r;
  logic [64:0]                   lhs_sum;
  logic                          zone_hit;

  // Relay state.
  logic                          pickup_r;
  logic                          trip_r;
  logic [CWID-1:0]               z1_cnt_r;
  logic [CWID-1:0]               z2_cnt_r;
  logic [CWID-1:0]               bk_cnt_r;
  logic                          pickup_nxt;
  logic                          trip_nxt;
  logic                          trip_prev_nxt;
  logic [CWID-1:0]               z1_cnt_nxt;
  logic [CWID-1:0]               z2_cnt_nxt;
  logic [CWID-1:0]               bk_cnt_nxt;

  logic                          out_valid_r;
  logic                          out_trip_r;
  logic                          out_trip_prev_r;
  logic                          out_pickup_r;
  logic                          out_free;
  logic                          finish;

  // Selected zone circle.
  logic signed [mdr_pkg::PHASOR_W-1:0] cre;
  logic signed [mdr_pkg::PHASOR_W-1:0] cim;
  logic [mdr_pkg::RADIUS_W-1:0]        rad;
  logic [2:0]                          zk;

  assign out_free = !out_valid_r || out_ch.ready;
  assign finish   = (state_r == ST_DONE) && out_free;
  assign pop      = (state_r == ST_IDLE) && pop_valid;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.trip      = out_trip_r;
  assign out_ch.trip_prev = out_trip_prev_r;
  assign out_ch.pickup    = out_pickup_r;

  function automatic logic signed [32:0] sx(input logic signed [mdr_pkg::PHASOR_W-1:0] x);
    sx = {{17{x[15]}}, x};
  endfunction

  function automatic logic [CWID-1:0] sat_inc(input logic [CWID-1:0] c);
    sat_inc = (c == {CWID{1'b1}}) ? c : c + 1'b1;
  endfunction

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          if (pop_item.kind == mdr_pkg::KIND_CLEAR || pickup_r) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (step_r == mdr_pkg::STEP_W'(mdr_pkg::STEP_LAST)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CALC) begin
        step_r <= step_r + 1'b1;
      end else begin
        step_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= pop_item;
    end
  end

  // Pick the operation issued to the multiplier in this step.
  always_comb begin
    mzone = (step_r >= mdr_pkg::STEP_W'(mdr_pkg::ZONE1_BASE)) ? mdr_pkg::ZONE_1
                                                              : mdr_pkg::ZONE_2;
    if (mzone == mdr_pkg::ZONE_1) begin
      zk = 3'(step_r - mdr_pkg::STEP_W'(mdr_pkg::ZONE1_BASE));
    end else begin
      zk = 3'(step_r - mdr_pkg::STEP_W'(mdr_pkg::ZONE2_BASE));
    end
    if (state_r != ST_CALC || step_r == mdr_pkg::STEP_W'(mdr_pkg::STEP_LAST)) begin
      mop = mdr_pkg::MOP_NONE;
    end else if (step_r == mdr_pkg::STEP_W'(0)) begin
      mop = mdr_pkg::MOP_IR2;
    end else if (step_r == mdr_pkg::STEP_W'(1)) begin
      mop = mdr_pkg::MOP_II2;
    end else begin
      case (zk)
        3'd0:    mop = mdr_pkg::MOP_RR;
        3'd1:    mop = mdr_pkg::MOP_CRIR;
        3'd2:    mop = mdr_pkg::MOP_CIII;
        3'd3:    mop = mdr_pkg::MOP_CRII;
        3'd4:    mop = mdr_pkg::MOP_CIIR;
        3'd5:    mop = mdr_pkg::MOP_RHS;
        3'd6:    mop = mdr_pkg::MOP_DR2;
        default: mop = mdr_pkg::MOP_DI2;
      endcase
    end
  end

  // Circle settings of the zone being worked on.
  always_comb begin
    if (mzone == mdr_pkg::ZONE_1) begin
      cre = cfg.z1_center_re;
      cim = cfg.z1_center_im;
      rad = cfg.z1_radius;
    end else begin
      cre = cfg.z2_center_re;
      cim = cfg.z2_center_im;
      rad = cfg.z2_radius;
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mop)
      mdr_pkg::MOP_IR2: begin
        mul_a = sx(item_r.curr_re);
        mul_b = sx(item_r.curr_re);
      end
      mdr_pkg::MOP_II2: begin
        mul_a = sx(item_r.curr_im);
        mul_b = sx(item_r.curr_im);
      end
      mdr_pkg::MOP_RR: begin
        mul_a = {18'b0, rad};
        mul_b = {18'b0, rad};
      end
      mdr_pkg::MOP_CRIR: begin
        mul_a = sx(cre);
        mul_b = sx(item_r.curr_re);
      end
      mdr_pkg::MOP_CIII: begin
        mul_a = sx(cim);
        mul_b = sx(item_r.curr_im);
      end
      mdr_pkg::MOP_CRII: begin
        mul_a = sx(cre);
        mul_b = sx(item_r.curr_im);
      end
      mdr_pkg::MOP_CIIR: begin
        mul_a = sx(cim);
        mul_b = sx(item_r.curr_re);
      end
      mdr_pkg::MOP_RHS: begin
        mul_a = {3'b0, rr_r};
        mul_b = {1'b0, i2_r};
      end
      mdr_pkg::MOP_DR2: begin
        mul_a = dr_r;
        mul_b = dr_r;
      end
      mdr_pkg::MOP_DI2: begin
        mul_a = di_r;
        mul_b = di_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The product register carries the operation and zone it belongs to.
  always_ff @(posedge clk) begin
    p_r     <= mul_a * mul_b;
    mop_r   <= mop;
    mzone_r <= mzone;
  end

  // Final zone compare: |V*4096 - c*I|^2 < r^2*|I|^2, never met with zero current.
  assign lhs_sum  = {1'b0, lhs_r} + {1'b0, p_r[63:0]};
  assign zone_hit = (i2_r != '0) && (lhs_sum < {1'b0, rhs_r});

  // Consume the product of the previous step.
  always_ff @(posedge clk) begin
    case (mop_r)
      mdr_pkg::MOP_IR2:  i2_r  <= p_r[31:0];
      mdr_pkg::MOP_II2:  i2_r  <= i2_r + p_r[31:0];
      mdr_pkg::MOP_RR:   rr_r  <= p_r[29:0];
      mdr_pkg::MOP_CRIR: dr_r  <= {{5{item_r.volt_re[15]}}, item_r.volt_re, 12'b0}
                                  - p_r[32:0];
      mdr_pkg::MOP_CIII: dr_r  <= dr_r + p_r[32:0];
      mdr_pkg::MOP_CRII: di_r  <= {{5{item_r.volt_im[15]}}, item_r.volt_im, 12'b0}
                                  - p_r[32:0];
      mdr_pkg::MOP_CIIR: di_r  <= di_r - p_r[32:0];
      mdr_pkg::MOP_RHS:  rhs_r <= p_r[63:0];
      mdr_pkg::MOP_DR2:  lhs_r <= p_r[63:0];
      mdr_pkg::MOP_DI2: begin
        if (mzone_r == mdr_pkg::ZONE_1) begin
          in_z1_r <= zone_hit;
        end else begin
          in_z2_r <= zone_hit;
        end
      end
      default: begin
        i2_r <= i2_r;
      end
    endcase
  end

  // Counter and trip update for the finished item.
  always_comb begin
    z1_cnt_nxt    = z1_cnt_r;
    z2_cnt_nxt    = z2_cnt_r;
    bk_cnt_nxt    = bk_cnt_r;
    pickup_nxt    = pickup_r;
    trip_nxt      = trip_r;
    trip_prev_nxt = trip_r;
    if (item_r.kind == mdr_pkg::KIND_CLEAR) begin
      z1_cnt_nxt    = '0;
      z2_cnt_nxt    = '0;
      bk_cnt_nxt    = '0;
      pickup_nxt    = 1'b0;
      trip_nxt      = 1'b0;
      trip_prev_nxt = 1'b0;
    end else begin
      // Zone timers run only while pickup is clear.
      if (!pickup_r) begin
        if (in_z2_r) begin
          z2_cnt_nxt = sat_inc(z2_cnt_r);
          z1_cnt_nxt = in_z1_r ? sat_inc(z1_cnt_r) : '0;
        end else begin
          z2_cnt_nxt = '0;
        end
      end
      // A timed-out zone runs the breaker delay, which ends in a trip.
      if (33'(z1_cnt_nxt) > 33'(cfg.z1_delay) || 33'(z2_cnt_nxt) > 33'(cfg.z2_delay)) begin
        bk_cnt_nxt = sat_inc(bk_cnt_r);
        if (33'(bk_cnt_nxt) > 33'(BREAKER_DELAY_TICKS)) begin
          trip_nxt   = 1'b1;
          pickup_nxt = 1'b0;
          z1_cnt_nxt = '0;
          z2_cnt_nxt = '0;
          bk_cnt_nxt = '0;
        end else begin
          trip_nxt   = 1'b0;
          pickup_nxt = 1'b1;
        end
      end else begin
        pickup_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pickup_r <= 1'b0;
      trip_r   <= 1'b0;
      z1_cnt_r <= '0;
      z2_cnt_r <= '0;
      bk_cnt_r <= '0;
    end else if (finish) begin
      pickup_r <= pickup_nxt;
      trip_r   <= trip_nxt;
      z1_cnt_r <= z1_cnt_nxt;
      z2_cnt_r <= z2_cnt_nxt;
      bk_cnt_r <= bk_cnt_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_trip_r      <= trip_nxt;
      out_trip_prev_r <= trip_prev_nxt;
      out_pickup_r    <= pickup_nxt;
    end
  end

endmodule

>>> design/two_zone_mho_distance_relay.sv
// Top level of the two-zone mho distance relay: settings registers, front end, queue, back end.
// Each item is one protection tick (voltage and current phasors in Q4.12) or a clear request,
// and yields one result item with trip, the trip status before the tick, and pickup. The front
// end takes an item every cycle until its input register and the QUEUE_DEPTH-entry queue are
// full. The back end sets the rate: it takes a tick from the queue, runs its schedule on the
// single shared 33 by 33 bit multiplier (two steps for |I|^2, eight per zone circle, one for
// the last compare), then updates the counters and loads the result register, waiting while
// the result register is still full; it takes no new item before that. A clear item, or a
// tick that arrives while pickup is set, skips the multiplier. Settings are written through
// the cfg channel, which is always ready, and should be changed only while no item is in flight.
module two_zone_mho_distance_relay #(
  parameter int unsigned BREAKER_DELAY_TICKS = mdr_pkg::DEF_BREAKER_DELAY_TICKS,
  parameter int          COUNT_WIDTH         = mdr_pkg::DEF_COUNT_WIDTH,
  parameter int          QUEUE_DEPTH         = mdr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  mdr_in_if.sink     in_ch,
  mdr_out_if.source  out_ch,
  mdr_cfg_if.sink    cfg_ch
);

  mdr_pkg::cfg_t     cfg_r;
  logic              push_valid;
  logic              push_ready;
  mdr_pkg::q_entry_t push_item;
  logic              pop_valid;
  logic              pop;
  mdr_pkg::q_entry_t pop_item;

  // Settings register file; unknown indexes are ignored.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        mdr_pkg::REG_Z1_CENTER_RE: cfg_r.z1_center_re <= cfg_ch.data;
        mdr_pkg::REG_Z1_CENTER_IM: cfg_r.z1_center_im <= cfg_ch.data;
        mdr_pkg::REG_Z1_RADIUS:    cfg_r.z1_radius    <= cfg_ch.data[mdr_pkg::RADIUS_W-1:0];
        mdr_pkg::REG_Z2_CENTER_RE: cfg_r.z2_center_re <= cfg_ch.data;
        mdr_pkg::REG_Z2_CENTER_IM: cfg_r.z2_center_im <= cfg_ch.data;
        mdr_pkg::REG_Z2_RADIUS:    cfg_r.z2_radius    <= cfg_ch.data[mdr_pkg::RADIUS_W-1:0];
        mdr_pkg::REG_Z1_DELAY:     cfg_r.z1_delay     <= cfg_ch.data;
        mdr_pkg::REG_Z2_DELAY:     cfg_r.z2_delay     <= cfg_ch.data;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Front end: accept and classify.
  mdr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Queue between the two ends.
  mdr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // Back end: zone tests, timers and result.
  mdr_back #(
    .BREAKER_DELAY_TICKS (BREAKER_DELAY_TICKS),
    .COUNT_WIDTH         (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule
